@@ sv/ctm_pkg.sv @@
// Shared constants, types and character helpers for the case-insensitive text matcher.
package ctm_pkg;

   localparam int MAX_QUERY_DEFAULT = 32;

   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 5;
   localparam int MODE_W      = 2;
   localparam int LENGTH_W    = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FUZZY_MODE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_LENGTH = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_CASE_BIT  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;

   typedef struct packed {
      logic text;
      logic finish;
   } step_type;

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] folded;
      folded = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         folded = c | CHAR_CASE_BIT;
      end
      return folded;
   endfunction

   function automatic logic is_sep(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_UNDERSCORE) ||
             (c >= CHAR_TAB && c <= CHAR_RETURN);
   endfunction

endpackage

@@ sv/ctm_query_store.sv @@
// Query byte lanes: stores folded query bytes and compares each against the text byte.
module ctm_query_store #(
   parameter int MAX_QUERY = ctm_pkg::MAX_QUERY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         write_en,
   input  logic [ctm_pkg::INDEX_W-1:0]  write_index,
   input  logic [ctm_pkg::CHAR_W-1:0]   write_char,
   input  logic [ctm_pkg::CHAR_W-1:0]   text_char,
   output logic [MAX_QUERY-1:0]         hit_vec,
   output logic [MAX_QUERY-1:0]         nonsep_vec
);
   import ctm_pkg::*;

   logic [CHAR_W-1:0] query_ff [MAX_QUERY];
   logic [CHAR_W-1:0] query_in [MAX_QUERY];
   logic [MAX_QUERY-1:0] sep_ff;
   logic [MAX_QUERY-1:0] sep_in;
   logic [CHAR_W-1:0] text_folded;

   always_comb begin
      for (int i = 0; i < MAX_QUERY; i++) begin
         query_in[i] = query_ff[i];
         sep_in[i]   = sep_ff[i];
         if (write_en && (32'(write_index) == i)) begin
            query_in[i] = fold_char(write_char);
            sep_in[i]   = is_sep(write_char);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_QUERY; i++) begin
         query_ff[i] <= query_in[i];
      end
      sep_ff <= sep_in;
   end

   assign text_folded = fold_char(text_char);

   always_comb begin
      for (int i = 0; i < MAX_QUERY; i++) begin
         hit_vec[i]    = (query_ff[i] == text_folded);
         nonsep_vec[i] = !sep_ff[i];
      end
   end

endmodule

@@ sv/ctm_match_core.sv @@
// Match state: shift-and substring vector and in-order subsequence position.
module ctm_match_core #(
   parameter int MAX_QUERY = ctm_pkg::MAX_QUERY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctm_pkg::step_type             step,
   input  logic                          text_sep,
   input  logic                          fuzzy_mode,
   input  logic [ctm_pkg::LENGTH_W-1:0]  query_length,
   input  logic [MAX_QUERY-1:0]          hit_vec,
   input  logic [MAX_QUERY-1:0]          nonsep_vec,
   output logic                          matched
);
   import ctm_pkg::*;

   localparam int LEN_W = $clog2(MAX_QUERY + 1);

   logic [MAX_QUERY-1:0] pmv_ff, pmv_in;
   logic [LEN_W-1:0]     pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic                 seen_ff, seen_in;

   logic [LEN_W-1:0]     len_eff;
   logic [MAX_QUERY-1:0] below_len, at_or_past_pos, last_mask;
   logic [MAX_QUERY:0]   pmv_shifted;
   logic [MAX_QUERY-1:0] pmv_step;
   logic [MAX_QUERY-1:0] cand, first_cand;
   logic                 any_cand, advance;
   logic [LEN_W-1:0]     first_idx, pos_text;

   assign len_eff = (32'(query_length) > MAX_QUERY) ? LEN_W'(MAX_QUERY)
                                                    : LEN_W'(query_length);

   always_comb begin
      for (int i = 0; i < MAX_QUERY; i++) begin
         below_len[i]      = (i < int'(len_eff));
         at_or_past_pos[i] = (i >= int'(pos_ff));
         last_mask[i]      = ((i + 1) == int'(len_eff));
      end
   end

   assign pmv_shifted = {pmv_ff, 1'b1};
   assign pmv_step    = hit_vec & pmv_shifted[MAX_QUERY-1:0];

   assign cand       = nonsep_vec & below_len & at_or_past_pos;
   assign first_cand = cand & (~cand + 1'b1);
   assign any_cand   = |cand;
   assign advance    = (|(first_cand & hit_vec)) && !text_sep;

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < MAX_QUERY; i++) begin
         if (first_cand[i]) begin
            first_idx = first_idx | LEN_W'(i);
         end
      end
   end

   always_comb begin
      if (any_cand) begin
         pos_text = advance ? first_idx + 1'b1 : first_idx;
      end else begin
         pos_text = (pos_ff >= len_eff) ? pos_ff : len_eff;
      end
   end

   always_comb begin
      pmv_in   = pmv_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      seen_in  = seen_ff;
      priority if (step.finish) begin
         pmv_in   = '0;
         pos_in   = '0;
         found_in = 1'b0;
         seen_in  = 1'b0;
      end else if (step.text) begin
         pmv_in   = pmv_step;
         pos_in   = pos_text;
         found_in = found_ff || (|(pmv_step & last_mask));
         seen_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmv_ff   <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         pmv_ff   <= pmv_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
         seen_ff  <= seen_in;
      end
   end

   always_comb begin
      if (len_eff == '0) begin
         matched = 1'b1;
      end else if (fuzzy_mode) begin
         matched = seen_ff && !any_cand;
      end else begin
         matched = found_ff;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= MAX_QUERY)
      else $error("fuzzy position beyond query store");

   a_found_needs_text: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> seen_ff)
      else $error("substring hit recorded without any text beat");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      step.finish |=> (pmv_ff == '0) && (pos_ff == '0) && !found_ff && !seen_ff)
      else $error("match state not cleared after end of text");

endmodule

@@ sv/case_insensitive_text_match.sv @@
// Top level of the case-insensitive text matcher.
//
// The request channel carries three kinds of beat: a query byte written at
// req_query_index, a text byte, and an end-of-text marker. Only the end-of-text
// beat produces a response beat; rsp_matched tells whether the text streamed
// since the previous end-of-text matched the stored query, ignoring ASCII case.
// The csr port sets fuzzy_mode (index 0) and query_length (index 1); write it
// only while no beat is in flight.
// A request beat is captured in an input register; a text or query beat is
// processed in the next cycle; end-of-text beats load the response register.
// The block accepts one beat per cycle while req_stall is low. Every query lane
// compares against the text byte in parallel, so the throughput does not depend
// on query length. When the response register holds a beat that rsp_stall keeps
// waiting, text and query beats still flow; only a further end-of-text beat
// waits in the input register, and req_stall rises once that register is full.
// Synchronous reset clears the match state, the csr registers and both valids;
// query bytes are undefined until written.
module case_insensitive_text_match #(
   parameter int MAX_QUERY = ctm_pkg::MAX_QUERY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ctm_pkg::MODE_W-1:0]      req_mode,
   input  logic [ctm_pkg::CHAR_W-1:0]      req_character,
   input  logic [ctm_pkg::INDEX_W-1:0]     req_query_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_matched,
   input  logic                            csr_write_en,
   input  logic [ctm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ctm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ctm_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0]   s1_mode_ff;
   logic [CHAR_W-1:0]   s1_char_ff;
   logic [INDEX_W-1:0]  s1_index_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_matched_ff;
   logic                fuzzy_ff, fuzzy_in;
   logic [LENGTH_W-1:0] qlen_ff, qlen_in;

   logic     s1_is_end, s1_go, req_accept, query_write, core_matched;
   step_type step;

   assign s1_is_end  = (s1_mode_ff == MODE_END);
   assign s1_go      = s1_valid_ff && (!s1_is_end || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   assign step.text   = s1_go && (s1_mode_ff == MODE_TEXT);
   assign step.finish = s1_go && s1_is_end;
   assign query_write = s1_go && (s1_mode_ff == MODE_QUERY);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      fuzzy_in = fuzzy_ff;
      qlen_in  = qlen_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FUZZY_MODE: begin
               fuzzy_in = csr_data[0];
            end
            CSR_QUERY_LENGTH: begin
               qlen_in = csr_data[LENGTH_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fuzzy_ff     <= 1'b0;
         qlen_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fuzzy_ff     <= fuzzy_in;
         qlen_ff      <= qlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff  <= req_mode;
         s1_char_ff  <= req_character;
         s1_index_ff <= req_query_index;
      end
      if (step.finish) begin
         rsp_matched_ff <= core_matched;
      end
   end

   logic [MAX_QUERY-1:0] hit_vec, nonsep_vec;

   ctm_query_store #(
      .MAX_QUERY (MAX_QUERY)
   ) u_store (
      .clock       (clock),
      .write_en    (query_write),
      .write_index (s1_index_ff),
      .write_char  (s1_char_ff),
      .text_char   (s1_char_ff),
      .hit_vec     (hit_vec),
      .nonsep_vec  (nonsep_vec)
   );

   ctm_match_core #(
      .MAX_QUERY (MAX_QUERY)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .text_sep     (is_sep(s1_char_ff)),
      .fuzzy_mode   (fuzzy_ff),
      .query_length (qlen_ff),
      .hit_vec      (hit_vec),
      .nonsep_vec   (nonsep_vec),
      .matched      (core_matched)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   a_stall_only_on_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_is_end && rsp_valid_ff)
      else $error("input stalled without a waiting end-of-text beat");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step.finish))
      else $error("response raised without an end-of-text beat");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !step.finish |=> !rsp_valid_ff)
      else $error("taken response beat not retired");

endmodule
